// ----- sv/tprsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tprsp_pkg
// shared types and constants of the three phase ramped soft pwm block
// ----------------------------------------------------------------------------
package tprsp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_SPAN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_B_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_C_OFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_SEC   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SECS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SECS = 3'd7;

    localparam logic [1:0] OP_SLOW = 2'd0;
    localparam logic [1:0] OP_RAMP = 2'd1;
    localparam logic [1:0] OP_PWM  = 2'd2;

    localparam logic [3:0] AUX_DUTY_LOW  = 4'd2;
    localparam logic [3:0] AUX_DUTY_HIGH = 4'd10;

    // quotient bits of a duty division on the shared divider
    localparam int DIV_STEPS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SDIV,
        ST_PAIR,
        ST_QDIV,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture item and run slow, pwm and toggle updates
        logic sdiv_start; // start span/voltage division
        logic sdiv_step;
        logic pair_step;  // step sequencer of current pair
        logic qdiv_start; // start duty division
        logic qdiv_step;
        logic next_pair;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_ramp;
        logic div_done;
        logic need_div;
        logic last_pair;
    } t_sts;

endpackage

// ----- sv/tprsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tprsp_ctrl
// sequencer for one transaction: divisions and pair stepping
// ----------------------------------------------------------------------------
module tprsp_ctrl import tprsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output logic o_ready,
    output logic o_res_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (!i_sts.is_ramp) begin
                    n_state = ST_OUT;
                end else if (i_sts.div_done) begin
                    n_state = ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (i_sts.need_div) begin
                    n_state = ST_QDIV;
                end else if (i_sts.last_pair) begin
                    n_state = ST_OUT;
                end
            end
            ST_QDIV: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.last_pair ? ST_OUT : ST_PAIR;
                end
            end
            ST_OUT: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.load     = i_valid;
                o_cmd.sdiv_start = i_valid;
            end
            ST_SDIV: begin
                o_cmd.sdiv_step = i_sts.is_ramp;
            end
            ST_PAIR: begin
                o_cmd.pair_step  = 1'b1;
                o_cmd.qdiv_start = i_sts.need_div;
                o_cmd.next_pair  = !i_sts.need_div;
            end
            ST_QDIV: begin
                o_cmd.qdiv_step = 1'b1;
                o_cmd.next_pair = i_sts.div_done;
            end
            ST_OUT: begin
                o_res_valid = !i_out_busy;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/tprsp_dp.sv -----
// ----------------------------------------------------------------------------
// tprsp_dp
// datapath: config, sequencers, shared restoring divider, pwm counters
// ----------------------------------------------------------------------------
module tprsp_dp import tprsp_pkg::*; #(
    parameter int PHASE_PAIRS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_op,
    input  logic [9:0]            i_voltage_sample,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [5:0]            o_lines,
    output logic                  o_toggle,
    output logic                  o_aux
);

    localparam int NCH = 2 * PHASE_PAIRS;
    localparam int PW  = (PHASE_PAIRS > 1) ? $clog2(PHASE_PAIRS) : 1;

    logic [6:0] r_span, r_boff, r_coff, r_first, r_second;
    logic [7:0] r_pwm_per, r_aux_per;
    logic [5:0] r_tps;

    logic [2:0] r_phase [PHASE_PAIRS];
    logic [7:0] r_step  [NCH];
    logic [7:0] r_duty  [NCH];
    logic [7:0] r_cnt   [NCH];
    logic [5:0] r_lines;
    logic [7:0] r_tcnt;
    logic       r_tlvl;
    logic [3:0] r_aux_duty;
    logic [7:0] r_aux_cnt;
    logic       r_aux_lvl;
    logic [5:0] r_sub;
    logic [7:0] r_secs;
    logic       r_isel;

    logic [1:0] r_op;
    logic [9:0] r_volt;
    logic [PW-1:0] r_pair;
    logic [7:0] r_divisor;
    // shared divider: remainder, quotient, dividend, bit count
    logic [9:0] r_rem;
    logic [7:0] r_quo;
    logic [9:0] r_dden;
    logic [3:0] r_dcnt;
    logic [PW:0] r_dch; // channel slot within pair (bit 0) written on finish

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= 7'd10; r_pwm_per <= 8'd10; r_aux_per <= 8'd10;
            r_boff <= 7'd6; r_coff <= 7'd0; r_tps <= 6'd62;
            r_first <= 7'd60; r_second <= 7'd90;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RAMP_SPAN:   r_span    <= i_cfg_data[6:0];
                REG_PWM_PERIOD:  r_pwm_per <= i_cfg_data;
                REG_AUX_PERIOD:  r_aux_per <= i_cfg_data;
                REG_PHASE_B_OFF: r_boff    <= i_cfg_data[6:0];
                REG_PHASE_C_OFF: r_coff    <= i_cfg_data[6:0];
                REG_TICKS_SEC:   r_tps     <= i_cfg_data[5:0];
                REG_FIRST_SECS:  r_first   <= i_cfg_data[6:0];
                REG_SECOND_SECS: r_second  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ---------------- pair step combinational ----------------
    logic [7:0] w_off;
    logic [8:0] w_top;
    logic [2:0] w_ph;
    logic [7:0] w_a, w_b;
    logic       w_wa, w_wb;
    always_comb begin
        if (r_pair == PW'(0)) begin
            w_off = 8'd0;
        end else if (r_pair == PW'(1)) begin
            w_off = {1'b0, r_boff};
        end else begin
            w_off = {1'b0, r_coff};
        end
        w_top = {2'b0, r_span} + {1'b0, w_off};
        w_ph  = r_phase[r_pair];
        w_a   = r_step[{r_pair, 1'b0}];
        w_b   = r_step[{r_pair, 1'b1}];
        w_wa  = 1'b0;
        w_wb  = 1'b0;
        if (w_a <= w_off && w_ph == 3'd0) w_ph = 3'd1;
        if ({1'b0, w_a} >= w_top && w_ph == 3'd1) w_ph = 3'd2;
        if (w_ph == 3'd1) begin w_a = w_a + 8'd1; w_wa = 1'b1; end
        if (w_ph == 3'd2) begin w_a = w_a - 8'd1; w_wa = 1'b1; end
        if (w_a <= w_off && w_ph == 3'd2) begin w_ph = 3'd3; w_a = w_off; end
        if (w_ph == 3'd3) begin w_b = w_b + 8'd1; w_wb = 1'b1; end
        if ({1'b0, w_b} >= w_top && w_ph == 3'd3) w_ph = 3'd4;
        if (w_ph == 3'd4) begin w_b = w_b - 8'd1; w_wb = 1'b1; end
        if (w_b <= w_off && w_ph == 3'd4) begin w_ph = 3'd0; w_b = w_off; end
    end

    // at most one channel gets a divided duty per pair step; when the first
    // channel ends its ramp in the same step its duty drops to zero
    logic       w_wr;
    logic       w_slot;
    logic [7:0] w_val;
    always_comb begin
        w_wr   = w_wa | w_wb;
        w_slot = w_wb;
        w_val  = w_wb ? w_b : w_a;
    end
    wire w_pos = w_val > w_off;
    wire [7:0] w_diff = w_val - w_off;

    wire [9:0] w_vnz  = (i_voltage_sample == 10'd0) ? 10'd1 : i_voltage_sample;
    wire [9:0] w_trial = {r_rem[8:0], r_dden[9]};
    wire       w_sdiv_ge = {r_rem[8:0], r_dden[9]} >= r_volt;

    always_comb begin
        o_sts.is_ramp   = r_op == OP_RAMP;
        o_sts.div_done  = r_dcnt == 4'd1;
        o_sts.need_div  = w_wr & w_pos;
        o_sts.last_pair = r_pair == PW'(PHASE_PAIRS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_volt <= w_vnz;
        end
        if (i_cmd.sdiv_start) begin
            r_rem  <= 10'd0;
            r_dden <= {3'b0, r_span};
            r_quo  <= 8'd0;
        end else if (i_cmd.sdiv_step) begin
            if (w_sdiv_ge) begin
                r_rem <= w_trial - r_volt;
            end else begin
                r_rem <= w_trial;
            end
            r_dden <= {r_dden[8:0], 1'b0};
            r_quo  <= {r_quo[6:0], w_sdiv_ge};
            if (r_dcnt == 4'd1) begin
                r_divisor <= ({r_quo[6:0], w_sdiv_ge} == 8'd0) ? 8'd1
                                                               : {r_quo[6:0], w_sdiv_ge};
            end
        end else if (i_cmd.qdiv_start) begin
            r_rem  <= 10'd0;
            r_dden <= {w_diff, 2'b0};
            r_quo  <= 8'd0;
            r_dch  <= {r_pair, w_slot};
        end else if (i_cmd.qdiv_step) begin
            if (w_trial >= {2'b0, r_divisor}) begin
                r_rem <= w_trial - {2'b0, r_divisor};
            end else begin
                r_rem <= w_trial;
            end
            r_dden <= {r_dden[8:0], 1'b0};
            r_quo  <= {r_quo[6:0], w_trial >= {2'b0, r_divisor}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= 4'd0;
            r_pair <= '0;
        end else begin
            if (i_cmd.sdiv_start) begin
                r_dcnt <= 4'd10;
            end else if (i_cmd.qdiv_start) begin
                r_dcnt <= 4'(DIV_STEPS);
            end else if ((i_cmd.sdiv_step || i_cmd.qdiv_step) && r_dcnt != 4'd0) begin
                r_dcnt <= r_dcnt - 4'd1;
            end
            if (i_cmd.load) begin
                r_pair <= '0;
            end else if (i_cmd.next_pair) begin
                r_pair <= (r_pair == PW'(PHASE_PAIRS - 1)) ? '0 : r_pair + PW'(1);
            end
        end
    end

    // ---------------- state updates ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PHASE_PAIRS; p++) r_phase[p] <= 3'd0;
            for (int n = 0; n < NCH; n++) begin
                r_step[n] <= 8'd0; r_duty[n] <= 8'd0; r_cnt[n] <= 8'd0;
            end
            r_lines <= 6'd0; r_tcnt <= 8'd0; r_tlvl <= 1'b0;
            r_aux_duty <= AUX_DUTY_LOW; r_aux_cnt <= 8'd0; r_aux_lvl <= 1'b0;
            r_sub <= 6'd0; r_secs <= 8'd0; r_isel <= 1'b0;
        end else begin
            if (i_cmd.load && i_op == OP_RAMP) begin
                if (r_tcnt == 8'({r_span, 1'b0} - 8'd1)) begin
                    r_tlvl <= ~r_tlvl;
                    r_tcnt <= 8'd1;
                end else begin
                    r_tcnt <= r_tcnt + 8'd1;
                end
            end
            if (i_cmd.load && i_op == OP_PWM) begin
                for (int n = 0; n < NCH; n++) begin
                    if (n < 6) r_lines[n] <= r_duty[n] >= r_cnt[n];
                    r_cnt[n] <= (r_cnt[n] >= r_pwm_per) ? 8'd1 : r_cnt[n] + 8'd1;
                end
                if ({4'b0, r_aux_duty} < r_aux_cnt) r_aux_lvl <= 1'b0;
                if ({4'b0, r_aux_duty} > r_aux_cnt) r_aux_lvl <= 1'b1;
                r_aux_cnt <= (r_aux_cnt > r_aux_per) ? 8'd1 : r_aux_cnt + 8'd1;
            end
            if (i_cmd.load && i_op == OP_SLOW) begin : slow
                logic [5:0] v_sub;
                logic [7:0] v_secs;
                logic       v_isel;
                logic [3:0] v_aux;
                v_sub  = r_sub + 6'd1;
                v_secs = r_secs;
                v_isel = r_isel;
                v_aux  = r_aux_duty;
                if (v_sub == r_tps) begin
                    v_secs = v_secs + 8'd1;
                    v_sub  = 6'd0;
                end
                // both interval ends may fire on one tick
                if (v_secs == {1'b0, r_first} && !v_isel) begin
                    v_secs = 8'd0; v_isel = 1'b1; v_aux = AUX_DUTY_LOW;
                end
                if (v_secs == {1'b0, r_second} && v_isel) begin
                    v_secs = 8'd0; v_isel = 1'b0; v_aux = AUX_DUTY_HIGH;
                end
                r_sub      <= v_sub;
                r_secs     <= v_secs;
                r_isel     <= v_isel;
                r_aux_duty <= v_aux;
            end
            if (i_cmd.pair_step) begin
                r_phase[r_pair] <= w_ph;
                r_step[{r_pair, 1'b0}] <= w_a;
                r_step[{r_pair, 1'b1}] <= w_b;
                if (w_wr && !w_pos) r_duty[{r_pair, w_slot}] <= 8'd0;
                if (w_wa && w_wb) r_duty[{r_pair, 1'b0}] <= 8'd0;
            end
            if (i_cmd.qdiv_step && r_dcnt == 4'd1) begin
                r_duty[r_dch] <= {r_quo[6:0], w_trial >= {2'b0, r_divisor}};
            end
        end
    end

    assign o_lines  = r_lines;
    assign o_toggle = r_tlvl;
    assign o_aux    = r_aux_lvl;

endmodule

// ----- sv/three_phase_ramped_soft_pwm.sv -----
// ----------------------------------------------------------------------------
// three_phase_ramped_soft_pwm
// ramped three phase soft pwm with auxiliary channel and interval timer
// ----------------------------------------------------------------------------
// slow and pwm ticks go from idle through the divide state straight to the output
// state; ramp ticks run through the shared restoring divider (one quotient bit a
// cycle) that first forms span/voltage and then each new duty;
// one transaction at a time; ready is high only while idle
// synchronous active low reset restores register defaults and clears state
module three_phase_ramped_soft_pwm import tprsp_pkg::*; #(
    parameter int PHASE_PAIRS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [9:0]            i_voltage_sample,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [5:0]            o_channel_lines,
    output logic                  o_toggle_line,
    output logic                  o_aux_line
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_res_valid;
    logic [5:0] w_lines;
    logic w_toggle, w_aux;

    // output register parts the result from the next transaction
    logic r_ovalid;
    logic [5:0] r_lines;
    logic r_toggle, r_aux;
    wire w_out_busy = r_ovalid && !i_ready;

    tprsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_busy (w_out_busy),
        .i_sts      (w_sts),
        .o_ready    (o_ready),
        .o_res_valid(w_res_valid),
        .o_cmd      (w_cmd)
    );

    tprsp_dp #(.PHASE_PAIRS(PHASE_PAIRS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_voltage_sample(i_voltage_sample),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_lines         (w_lines),
        .o_toggle        (w_toggle),
        .o_aux           (w_aux)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_lines  <= w_lines;
            r_toggle <= w_toggle;
            r_aux    <= w_aux;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_channel_lines = r_lines;
    assign o_toggle_line   = r_toggle;
    assign o_aux_line      = r_aux;

endmodule

// ----- sv/tprsp_checker.sv -----
// ----------------------------------------------------------------------------
// tprsp_checker
// port level checks of the three phase ramped soft pwm block
// ----------------------------------------------------------------------------
module tprsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [5:0] o_channel_lines
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_channel_lines))
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted while previous transaction busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind three_phase_ramped_soft_pwm tprsp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_channel_lines(o_channel_lines)
);
